@@ design/boil_pkg.sv @@
// Shared types and constants for the bounded ordered identifier list.
// Holds the command codes, the transfer payload structs and the store control struct.
// Depends on nothing.
package boil_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int ID_WIDTH_DEF = 32;

   localparam int CMD_W   = 3;
   localparam int FIELD_ID_W = 32;
   localparam int SLOT_W  = 4;
   localparam int COUNT_W = 5;

   localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_APPEND = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]      cmd;
      logic [FIELD_ID_W-1:0] item_id;
      logic                  anchor_given;
      logic [FIELD_ID_W-1:0] anchor_id;
      logic [SLOT_W-1:0]     slot_index;
   } boil_req_type;

   typedef struct packed {
      logic                  ok;
      logic [SLOT_W-1:0]     found_slot;
      logic [FIELD_ID_W-1:0] found_id;
      logic [COUNT_W-1:0]    entry_count;
   } boil_rsp_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } store_ctl_type;

endpackage

@@ design/bounded_ordered_id_list.sv @@
// Bounded ordered list of distinct nonzero identifiers, one command at a time.
// The search and the shift walk the store through its single read port, one entry per cycle.
// The next transfer waits until the result is registered; a stalled result holds it off.
// Reset clears the count, not the store.
module bounded_ordered_id_list #(
   parameter int CAPACITY = boil_pkg::CAPACITY_DEF,
   parameter int ID_WIDTH = boil_pkg::ID_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  boil_pkg::boil_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output boil_pkg::boil_rsp_type rsp_data
);
   import boil_pkg::*;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int CNT_W   = $clog2(CAPACITY + 1);
   localparam int KEEP_W  = (ID_WIDTH < FIELD_ID_W) ? ID_WIDTH : FIELD_ID_W;
   localparam int IDX_CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // Sequencer states
   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] ST_SCAN   = 3'd1;
   localparam logic [STATE_W-1:0] ST_READ   = 3'd2;
   localparam logic [STATE_W-1:0] ST_DECIDE = 3'd3;
   localparam logic [STATE_W-1:0] ST_SHIFT  = 3'd4;
   localparam logic [STATE_W-1:0] ST_WRAP   = 3'd5;
   localparam logic [STATE_W-1:0] ST_RESP   = 3'd6;

   logic [STATE_W-1:0]  state_ff, state_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;
   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                anchor_given_ff, anchor_given_in;
   logic [ID_WIDTH-1:0] anchor_ff, anchor_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic                item_hit_ff, item_hit_in;
   logic [ADDR_W-1:0]   item_pos_ff, item_pos_in;
   logic                anchor_hit_ff, anchor_hit_in;
   logic [ADDR_W-1:0]   anchor_pos_ff, anchor_pos_in;
   logic [ADDR_W-1:0]   sh_ptr_ff, sh_ptr_in;
   logic [CNT_W-1:0]    sh_rem_ff, sh_rem_in;
   logic                sh_fwd_ff, sh_fwd_in;
   logic [ADDR_W-1:0]   dst_ff, dst_in;
   logic                res_ok_ff, res_ok_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [FIELD_ID_W-1:0] res_id_ff, res_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   boil_rsp_type        rsp_data_ff, rsp_data_in;

   // Store port
   store_ctl_type       st_ctl;
   logic [ADDR_W-1:0]   st_rd_addr;
   logic [ADDR_W-1:0]   st_wr_addr;
   logic [ID_WIDTH-1:0] st_wr_data;
   logic                st_rd_vld;
   logic [ADDR_W-1:0]   st_rd_tag;
   logic [ID_WIDTH-1:0] st_rd_data;

   // Decision terms, all from registered request fields and search results
   logic                id_nz;
   logic                item_ok;
   logic                idx_ok;
   logic [CNT_W-1:0]    src_c;
   logic [CNT_W-1:0]    dst_raw;
   logic                move_fwd;
   logic [CNT_W-1:0]    move_dst;
   logic                move_ok;

   boil_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ID_WIDTH)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .rd_addr (st_rd_addr),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_vld  (st_rd_vld),
      .rd_tag  (st_rd_tag),
      .rd_data (st_rd_data)
   );

   assign id_nz   = (id_ff != '0);
   assign item_ok = id_nz && item_hit_ff;
   assign idx_ok  = IDX_CMP_W'(idx_ff) < IDX_CMP_W'(used_ff);
   assign src_c   = CNT_W'(item_pos_ff);

   // Without an anchor the target is the end of the list. Taking the item out
   // first pulls a later target down by one.
   assign dst_raw  = anchor_given_ff ? CNT_W'(anchor_pos_ff) : used_ff;
   assign move_fwd = src_c < dst_raw;
   assign move_dst = move_fwd ? dst_raw - 1'b1 : dst_raw;
   assign move_ok  = item_ok
                     && !(anchor_given_ff && (anchor_ff == id_ff))
                     && !(anchor_given_ff && !anchor_hit_ff)
                     && (src_c != move_dst)
                     && (move_dst < CNT_W'(CAPACITY));

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      id_in           = id_ff;
      anchor_given_in = anchor_given_ff;
      anchor_in       = anchor_ff;
      idx_in          = idx_ff;
      used_in         = used_ff;
      scan_ptr_in     = scan_ptr_ff;
      item_hit_in     = item_hit_ff;
      item_pos_in     = item_pos_ff;
      anchor_hit_in   = anchor_hit_ff;
      anchor_pos_in   = anchor_pos_ff;
      sh_ptr_in       = sh_ptr_ff;
      sh_rem_in       = sh_rem_ff;
      sh_fwd_in       = sh_fwd_ff;
      dst_in          = dst_ff;
      res_ok_in       = res_ok_ff;
      res_slot_in     = res_slot_ff;
      res_id_in       = res_id_ff;
      rsp_data_in     = rsp_data_ff;
      // Drop the held result once it transfers
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      st_ctl          = '0;
      st_rd_addr      = '0;
      st_wr_addr      = '0;
      st_wr_data      = id_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               // Identifiers count in their low KEEP_W bits only
               cmd_in          = req_data.cmd;
               id_in           = ID_WIDTH'(req_data.item_id[KEEP_W-1:0]);
               anchor_given_in = req_data.anchor_given;
               anchor_in       = ID_WIDTH'(req_data.anchor_id[KEEP_W-1:0]);
               idx_in          = req_data.slot_index;
               item_hit_in     = 1'b0;
               anchor_hit_in   = 1'b0;
               scan_ptr_in     = '0;
               case (req_data.cmd) inside
                  CMD_LOOKUP, CMD_APPEND, CMD_ERASE, CMD_MOVE: state_in = ST_SCAN;
                  CMD_READ:                                    state_in = ST_READ;
                  default:                                     state_in = ST_DECIDE;
               endcase
            end
         end

         ST_SCAN: begin
            // Walk the filled entries; compare each returned word against
            // both the item and the anchor.
            if (scan_ptr_ff < used_ff) begin
               st_ctl.rd_en = 1'b1;
               st_rd_addr   = scan_ptr_ff[ADDR_W-1:0];
               scan_ptr_in  = scan_ptr_ff + 1'b1;
            end else if (!st_rd_vld) begin
               state_in = ST_DECIDE;
            end
            if (st_rd_vld) begin
               if (st_rd_data == id_ff) begin
                  item_hit_in = 1'b1;
                  item_pos_in = st_rd_tag;
               end
               if (st_rd_data == anchor_ff) begin
                  anchor_hit_in = 1'b1;
                  anchor_pos_in = st_rd_tag;
               end
            end
         end

         ST_READ: begin
            st_ctl.rd_en = idx_ok;
            st_rd_addr   = ADDR_W'(idx_ff);
            state_in     = ST_DECIDE;
         end

         ST_DECIDE: begin
            res_ok_in   = 1'b0;
            res_slot_in = '0;
            res_id_in   = '0;
            state_in    = ST_RESP;
            unique case (cmd_ff)
               CMD_LOOKUP: begin
                  res_ok_in   = item_ok;
                  res_slot_in = SLOT_W'(item_pos_ff);
                  res_id_in   = FIELD_ID_W'(id_ff);
               end
               CMD_READ: begin
                  res_ok_in   = idx_ok;
                  res_slot_in = idx_ff;
                  res_id_in   = FIELD_ID_W'(st_rd_data);
               end
               CMD_APPEND: begin
                  res_ok_in   = id_nz && (used_ff < CNT_W'(CAPACITY)) && !item_hit_ff;
                  res_slot_in = SLOT_W'(used_ff);
                  res_id_in   = FIELD_ID_W'(id_ff);
                  if (res_ok_in) begin
                     st_ctl.wr_en = 1'b1;
                     st_wr_addr   = used_ff[ADDR_W-1:0];
                     st_wr_data   = id_ff;
                     used_in      = used_ff + 1'b1;
                  end
               end
               CMD_ERASE: begin
                  res_ok_in   = item_ok;
                  res_slot_in = SLOT_W'(item_pos_ff);
                  res_id_in   = FIELD_ID_W'(id_ff);
                  // Pull every later entry down by one
                  sh_fwd_in   = 1'b1;
                  sh_ptr_in   = item_pos_ff + 1'b1;
                  sh_rem_in   = used_ff - 1'b1 - src_c;
                  if (item_ok) begin
                     state_in = ST_SHIFT;
                  end
               end
               CMD_MOVE: begin
                  res_ok_in   = move_ok;
                  res_slot_in = SLOT_W'(move_dst);
                  res_id_in   = FIELD_ID_W'(id_ff);
                  dst_in      = move_dst[ADDR_W-1:0];
                  sh_fwd_in   = move_fwd;
                  if (move_fwd) begin
                     sh_ptr_in = item_pos_ff + 1'b1;
                     sh_rem_in = move_dst - src_c;
                  end else begin
                     sh_ptr_in = item_pos_ff - 1'b1;
                     sh_rem_in = src_c - move_dst;
                  end
                  if (move_ok) begin
                     state_in = ST_SHIFT;
                  end
               end
               default: begin
                  // Unused command codes fail with nothing changed
               end
            endcase
            if (!res_ok_in) begin
               res_slot_in = '0;
               res_id_in   = '0;
            end
         end

         ST_SHIFT: begin
            // One read issued and one word written back per cycle; each word
            // lands one place over from where it was read.
            if (sh_rem_ff != '0) begin
               st_ctl.rd_en = 1'b1;
               st_rd_addr   = sh_ptr_ff;
               sh_ptr_in    = sh_fwd_ff ? sh_ptr_ff + 1'b1 : sh_ptr_ff - 1'b1;
               sh_rem_in    = sh_rem_ff - 1'b1;
            end else if (!st_rd_vld) begin
               state_in = ST_WRAP;
            end
            if (st_rd_vld) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr   = sh_fwd_ff ? st_rd_tag - 1'b1 : st_rd_tag + 1'b1;
               st_wr_data   = st_rd_data;
            end
         end

         ST_WRAP: begin
            if (cmd_ff == CMD_MOVE) begin
               st_ctl.wr_en = 1'b1;
               st_wr_addr   = dst_ff;
               st_wr_data   = id_ff;
            end else begin
               used_in = used_ff - 1'b1;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            // Hold until the output register is free or empties this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.ok          = res_ok_ff;
               rsp_data_in.found_slot  = res_slot_ff;
               rsp_data_in.found_id    = res_id_ff;
               rsp_data_in.entry_count = COUNT_W'(used_ff);
               rsp_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      id_ff           <= id_in;
      anchor_given_ff <= anchor_given_in;
      anchor_ff       <= anchor_in;
      idx_ff          <= idx_in;
      scan_ptr_ff     <= scan_ptr_in;
      item_hit_ff     <= item_hit_in;
      item_pos_ff     <= item_pos_in;
      anchor_hit_ff   <= anchor_hit_in;
      anchor_pos_ff   <= anchor_pos_in;
      sh_ptr_ff       <= sh_ptr_in;
      sh_rem_ff       <= sh_rem_in;
      sh_fwd_ff       <= sh_fwd_in;
      dst_ff          <= dst_in;
      res_ok_ff       <= res_ok_in;
      res_slot_ff     <= res_slot_in;
      res_id_ff       <= res_id_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CNT_W'(CAPACITY)) else $error("entry count past capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(used_ff) |-> (used_ff == $past(used_ff) + 1'b1)
                            || (used_ff == $past(used_ff) - 1'b1))
      else $error("entry count jumped");

   a_write_in_fill: assert property (@(posedge clock) disable iff (reset)
      st_ctl.wr_en |-> CNT_W'(st_wr_addr) <= used_ff)
      else $error("store write beyond the filled entries");

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.ok)
         |-> (rsp_data_ff.found_slot == '0) && (rsp_data_ff.found_id == '0))
      else $error("failed command reports a position or identifier");

   a_result_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_RESP)
      else $error("result loaded outside the result state");

endmodule

@@ design/boil_store.sv @@
// Identifier store: one write port, one read port with registered read data.
// Tracks which address each returned word came from.
// Depends on boil_pkg.
module boil_store #(
   parameter int DEPTH = boil_pkg::CAPACITY_DEF,
   parameter int WIDTH = boil_pkg::ID_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  boil_pkg::store_ctl_type ctl,
   input  logic [ADDR_W-1:0]     rd_addr,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   output logic                  rd_vld,
   output logic [ADDR_W-1:0]     rd_tag,
   output logic [WIDTH-1:0]      rd_data
);
   import boil_pkg::*;

   logic [WIDTH-1:0]  mem [DEPTH];
   logic              rd_vld_ff;
   logic [ADDR_W-1:0] rd_tag_ff;
   logic [WIDTH-1:0]  rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      rd_tag_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= ctl.rd_en;
      end
   end

   assign rd_vld  = rd_vld_ff;
   assign rd_tag  = rd_tag_ff;
   assign rd_data = rd_data_ff;

   a_vld_follows_rd: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |=> rd_vld) else $error("read issued but no data returned");

   a_no_vld_without_rd: assert property (@(posedge clock) disable iff (reset)
      !ctl.rd_en |=> !rd_vld) else $error("data returned without a read");

   a_tag_matches: assert property (@(posedge clock) disable iff (reset)
      ctl.rd_en |=> rd_tag == $past(rd_addr)) else $error("read tag lost its address");

   a_no_same_addr: assert property (@(posedge clock) disable iff (reset)
      (ctl.rd_en && ctl.wr_en) |-> rd_addr != wr_addr)
      else $error("read and write hit one address");

endmodule
